// ===== rtl/sasi_pkg.sv =====
`default_nettype none
package sasi_pkg;
   localparam int unsigned CfgWidth = 17;
endpackage
`default_nettype wire

// ===== rtl/sasi_if.sv =====
`default_nettype none
interface sasi_req_if #(parameter int unsigned CW = 32) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] end_x;
   logic signed [CW-1:0] end_y;
   logic signed [CW-1:0] box_min_x;
   logic signed [CW-1:0] box_min_y;
   logic signed [CW-1:0] box_max_x;
   logic signed [CW-1:0] box_max_y;
   modport source (output valid, start_x, start_y, end_x, end_y, box_min_x, box_min_y,
                   box_max_x, box_max_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, box_min_x, box_min_y,
                 box_max_x, box_max_y, output ready);
endinterface

interface sasi_rsp_if #(parameter int unsigned CW = 32, parameter int unsigned FB = 16) ();
   logic valid;
   logic ready;
   logic hit;
   logic [FB:0] entry_param;
   logic signed [CW-1:0] hit_x;
   logic signed [CW-1:0] hit_y;
   modport source (output valid, hit, entry_param, hit_x, hit_y, input ready);
   modport sink (input valid, hit, entry_param, hit_x, hit_y, output ready);
endinterface

interface sasi_csr_if ();
   logic valid;
   logic ready;
   logic [sasi_pkg::CfgWidth-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sasi_div.sv =====
`default_nettype none
// One restoring-division step per pipeline stage; the stage register advances on enable.
module sasi_div #(
   parameter int unsigned NW = 33,
   parameter int unsigned FB = 16
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] num,
   input  wire logic [NW-1:0] den,
   output logic [FB+1:0]      quot
);
   localparam int unsigned RW = NW + 1;
   logic [RW-1:0] r_ff  [FB+1];
   logic [NW-1:0] d_ff  [FB+1];
   logic [FB+1:0] q_ff  [FB+1];
   logic          sat_ff[FB+1];

   // Stage zero: saturation check and integer bit.
   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= {1'b0, num} >= {den, 1'b0};
         d_ff[0]   <= den;
         if (num >= den) begin
            q_ff[0] <= (FB+2)'(1);
            r_ff[0] <= RW'(num - den);
         end else begin
            q_ff[0] <= '0;
            r_ff[0] <= RW'(num);
         end
      end
   end

   // One fraction bit per stage.
   for (genvar i = 1; i <= FB; i++) begin : g_step
      logic [RW-1:0] sh_in;
      assign sh_in = {r_ff[i-1][RW-2:0], 1'b0};
      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[i] <= sat_ff[i-1];
            d_ff[i]   <= d_ff[i-1];
            if (sh_in >= RW'(d_ff[i-1])) begin
               r_ff[i] <= sh_in - RW'(d_ff[i-1]);
               q_ff[i] <= {q_ff[i-1][FB:0], 1'b1};
            end else begin
               r_ff[i] <= sh_in;
               q_ff[i] <= {q_ff[i-1][FB:0], 1'b0};
            end
         end
      end
   end

   assign quot = sat_ff[FB] ? (FB+2)'(2) << FB : q_ff[FB];
endmodule
`default_nettype wire

// ===== rtl/segment_aabb_slab_intersect.sv =====
`default_nettype none
// Pipeline: difference stage, integer-bit stage and one divider stage per fraction bit,
//   compare, multiply, then scale and add.
// Throughput: one transfer per cycle; the whole pipeline stalls only when the output holds.
// Reset: valid bits clear, parallel_limit returns to 1; data registers are not reset.
module segment_aabb_slab_intersect #(
   parameter int unsigned COORD_WIDTH     = 32,
   parameter int unsigned PARAM_FRAC_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   sasi_req_if.sink  req,
   sasi_rsp_if.source rsp,
   sasi_csr_if.sink  csr
);
   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned FB = PARAM_FRAC_BITS;
   localparam int unsigned NW = CW + 1;
   localparam int unsigned TW = FB + 3;
   localparam int unsigned DL = FB + 1;
   localparam int unsigned NS = FB + 5;

   logic [sasi_pkg::CfgWidth-1:0] limit_ff;
   logic [NS-1:0] vld_ff;
   logic          en;

   // Whole pipeline advances unless the output holds an untaken result.
   assign en        = !(rsp.valid && !rsp.ready);
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sasi_pkg::CfgWidth'(1);
         vld_ff   <= '0;
      end else begin
         if (csr.valid) limit_ff <= csr.data;
         if (en) vld_ff <= {vld_ff[NS-2:0], req.valid};
      end
   end
   assign rsp.valid = vld_ff[NS-1];

   // Stage 1: differences, magnitudes, parallel test.
   logic signed [NW-1:0] d_ff [2], nl_ff [2], nh_ff [2];
   logic signed [CW-1:0] s_ff [2];
   logic                 par_ff [2], pin_ff [2];
   logic signed [CW-1:0] s_in [2], e_in [2], lo_in [2], hi_in [2];
   assign s_in  = '{req.start_x, req.start_y};
   assign e_in  = '{req.end_x, req.end_y};
   assign lo_in = '{req.box_min_x, req.box_min_y};
   assign hi_in = '{req.box_max_x, req.box_max_y};

   for (genvar a = 0; a < 2; a++) begin : g_ax1
      logic signed [NW-1:0] d_in;
      logic [NW-1:0] m_in;
      assign d_in = NW'(e_in[a]) - NW'(s_in[a]);
      assign m_in = d_in[NW-1] ? NW'(-d_in) : NW'(d_in);
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[a]   <= d_in;
            nl_ff[a]  <= NW'(lo_in[a]) - NW'(s_in[a]);
            nh_ff[a]  <= NW'(hi_in[a]) - NW'(s_in[a]);
            s_ff[a]   <= s_in[a];
            par_ff[a] <= (d_in == '0) || (m_in < NW'(limit_ff));
            pin_ff[a] <= (s_in[a] >= lo_in[a]) && (s_in[a] <= hi_in[a]);
         end
      end
   end

   // Dividers: four slab quotients, one bit per stage.
   logic [FB+1:0] ql [2], qh [2];
   for (genvar a = 0; a < 2; a++) begin : g_div
      logic [NW-1:0] ml, mh, md;
      assign ml = nl_ff[a][NW-1] ? NW'(-nl_ff[a]) : NW'(nl_ff[a]);
      assign mh = nh_ff[a][NW-1] ? NW'(-nh_ff[a]) : NW'(nh_ff[a]);
      assign md = d_ff[a][NW-1] ? NW'(-d_ff[a]) : NW'(d_ff[a]);
      sasi_div #(.NW(NW), .FB(FB)) u_dl (.clock, .en, .num(ml), .den(md), .quot(ql[a]));
      sasi_div #(.NW(NW), .FB(FB)) u_dh (.clock, .en, .num(mh), .den(md), .quot(qh[a]));
   end

   // Delay line carrying signs and side data alongside the dividers.
   logic signed [NW-1:0] dd_ff [DL][2];
   logic signed [CW-1:0] sd_ff [DL][2];
   logic                 parq_ff [DL][2], pinq_ff [DL][2], ngl_ff [DL][2], ngh_ff [DL][2];
   for (genvar k = 0; k < DL; k++) begin : g_dl
      for (genvar a = 0; a < 2; a++) begin : g_dla
         if (k == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (en) begin
                  dd_ff[k][a]   <= d_ff[a];
                  sd_ff[k][a]   <= s_ff[a];
                  parq_ff[k][a] <= par_ff[a];
                  pinq_ff[k][a] <= pin_ff[a];
                  ngl_ff[k][a]  <= nl_ff[a][NW-1] != d_ff[a][NW-1];
                  ngh_ff[k][a]  <= nh_ff[a][NW-1] != d_ff[a][NW-1];
               end
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (en) begin
                  dd_ff[k][a]   <= dd_ff[k-1][a];
                  sd_ff[k][a]   <= sd_ff[k-1][a];
                  parq_ff[k][a] <= parq_ff[k-1][a];
                  pinq_ff[k][a] <= pinq_ff[k-1][a];
                  ngl_ff[k][a]  <= ngl_ff[k-1][a];
                  ngh_ff[k][a]  <= ngh_ff[k-1][a];
               end
            end
         end
      end
   end

   // Interval narrowing over both axes.
   logic signed [TW-1:0] tl [2], th [2], t1 [2], t2 [2];
   logic signed [TW-1:0] tmin_c;
   logic hit_c;
   for (genvar a = 0; a < 2; a++) begin : g_sg
      logic [FB+1:0] cl, ch;
      assign cl = (ql[a] > (FB+2)'(1) << FB) ? (FB+2)'(1) << FB : ql[a];
      assign ch = (qh[a] > (FB+2)'(1) << FB) ? (FB+2)'(1) << FB : qh[a];
      assign tl[a] = ngl_ff[DL-1][a] ? -TW'(cl) : TW'(ql[a]);
      assign th[a] = ngh_ff[DL-1][a] ? -TW'(ch) : TW'(qh[a]);
      assign t1[a] = (tl[a] > th[a]) ? th[a] : tl[a];
      assign t2[a] = (tl[a] > th[a]) ? tl[a] : th[a];
   end
   always_comb begin
      logic signed [TW-1:0] lo, hi;
      lo = '0;
      hi = TW'(1) << FB;
      hit_c = 1'b1;
      for (int a = 0; a < 2; a++) begin
         if (parq_ff[DL-1][a]) begin
            if (!pinq_ff[DL-1][a]) hit_c = 1'b0;
         end else begin
            if (t1[a] > lo) lo = t1[a];
            if (t2[a] < hi) hi = t2[a];
            if (lo > hi) hit_c = 1'b0;
         end
      end
      tmin_c = lo;
   end

   logic          hit_ff;
   logic [FB:0]   t_ff;
   logic signed [NW-1:0] dc_ff [2];
   logic signed [CW-1:0] sc_ff [2];
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_c;
         t_ff   <= (FB+1)'(tmin_c);
         dc_ff  <= dd_ff[DL-1];
         sc_ff  <= sd_ff[DL-1];
      end
   end

   // Scale direction by tmin: product stage, then truncate and add.
   logic [NW+FB:0]      p_ff [2];
   logic                pn_ff [2];
   logic signed [CW-1:0] sp_ff [2];
   logic hit2_ff;
   logic [FB:0] t2_ff;
   for (genvar a = 0; a < 2; a++) begin : g_mul
      logic [NW-1:0] m;
      assign m = dc_ff[a][NW-1] ? NW'(-dc_ff[a]) : NW'(dc_ff[a]);
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[a]  <= (NW+FB+1)'(m) * (NW+FB+1)'(t_ff);
            pn_ff[a] <= dc_ff[a][NW-1];
            sp_ff[a] <= sc_ff[a];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hit2_ff <= hit_ff;
         t2_ff   <= t_ff;
      end
   end

   logic signed [CW-1:0] hx_ff, hy_ff;
   logic                 hit3_ff;
   logic [FB:0]          t3_ff;
   logic signed [NW-1:0] sc0, sc1;
   assign sc0 = pn_ff[0] ? -NW'(p_ff[0][NW+FB-1:FB]) : NW'(p_ff[0][NW+FB-1:FB]);
   assign sc1 = pn_ff[1] ? -NW'(p_ff[1][NW+FB-1:FB]) : NW'(p_ff[1][NW+FB-1:FB]);
   always_ff @(posedge clock) begin
      if (en) begin
         hit3_ff <= hit2_ff;
         t3_ff   <= hit2_ff ? t2_ff : '0;
         hx_ff   <= hit2_ff ? CW'(NW'(sp_ff[0]) + sc0) : '0;
         hy_ff   <= hit2_ff ? CW'(NW'(sp_ff[1]) + sc1) : '0;
      end
   end
   assign rsp.hit         = hit3_ff;
   assign rsp.entry_param = t3_ff;
   assign rsp.hit_x       = hx_ff;
   assign rsp.hit_y       = hy_ff;

`ifndef NO_ASSERTIONS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> rsp.entry_param == '0 && rsp.hit_x == '0)
      else $error("miss result not cleared");
   a_param_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.entry_param <= (FB+1)'(1) << FB)
      else $error("entry parameter above one");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.hit_x))
      else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
